// ===== sv/emrl_pkg.sv =====
// ============================================================================
// Elevon mixer package
// Shared types and constants of the rate-limited elevon mixer.
// ============================================================================
package emrl_pkg;

    localparam int unsigned CfgAddrW = 4;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW = 1;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] REG_ELEVATOR_GAIN    = 4'd0;
    localparam logic [CfgAddrW-1:0] REG_AILERON_GAIN     = 4'd1;
    localparam logic [CfgAddrW-1:0] REG_RUDDER_GAIN      = 4'd2;
    localparam logic [CfgAddrW-1:0] REG_MODE_BITS        = 4'd3;
    localparam logic [CfgAddrW-1:0] REG_ELEVON_LIMIT     = 4'd4;
    localparam logic [CfgAddrW-1:0] REG_RUDDER_LIMIT     = 4'd5;
    localparam logic [CfgAddrW-1:0] REG_THROTTLE_FLOOR   = 4'd6;
    localparam logic [CfgAddrW-1:0] REG_THROTTLE_CEILING = 4'd7;

    // Mode bit positions.
    localparam int unsigned MODE_ELEVON    = 0;
    localparam int unsigned MODE_REV_LEFT  = 1;
    localparam int unsigned MODE_REV_RIGHT = 2;
    localparam int unsigned MODE_REV_RUDDER = 3;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] GAIN_ONE  = 16'sd8192;
    localparam logic [14:0]        LIMIT_ONE = 15'd16384;
    localparam logic signed [15:0] THR_FLOOR_RST = 16'sd0;
    localparam logic signed [15:0] THR_CEIL_RST  = 16'sd16384;

    // Step size: floor(elapsed * 16384 / 1000), capped at 65536. Beyond
    // 4000 ms the cap always applies; below it a reciprocal multiply by
    // ceil(16.384 * 2^20) followed by a 20-bit shift is exact.
    localparam logic [31:0] STEP_CAP_MS = 32'd4000;
    localparam int unsigned ElapsedW    = 12;
    localparam logic [24:0] STEP_MUL    = 25'd17179870;
    localparam int unsigned StepShift   = 20;
    localparam int unsigned StepW       = 17;
    localparam logic [StepW-1:0] STEP_CAP = 17'd65536;

    typedef struct packed {
        logic signed [15:0] pitch_cmd;
        logic signed [15:0] roll_cmd;
        logic signed [15:0] yaw_cmd;
        logic signed [15:0] throttle_command;
        logic [31:0]        time_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_surface;
        logic signed [15:0] right_surface;
        logic signed [15:0] rudder_out;
        logic signed [15:0] throttle_out;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] elevator_gain;
        logic signed [15:0] aileron_gain;
        logic signed [15:0] rudder_gain;
        logic [3:0]         mode_bits;
        logic [14:0]        elevon_limit;
        logic [14:0]        rudder_limit;
        logic signed [15:0] throttle_floor;
        logic signed [15:0] throttle_ceiling;
    } cfg_t;

    // Item passed from the front end to the back end.
    typedef struct packed {
        logic signed [31:0]    elev_prod;
        logic signed [31:0]    ail_prod;
        logic signed [31:0]    rud_prod;
        logic signed [15:0]    throttle;
        logic                  hold;
        logic                  step_cap;
        logic [ElapsedW-1:0]   elapsed_lo;
    } mid_item_t;

endpackage

// ===== sv/elevon_mixer_rate_limited.sv =====
// ============================================================================
// Rate-limited elevon mixer
// Mixes pitch, roll and yaw commands onto two surfaces and a rudder with
// clamping and a 1.0 per second slew limit, and clamps the throttle.
// ============================================================================
// The block looks like a queue on both sides. An item is written with push
// while full is low; it carries the three rate commands, the throttle and a
// millisecond time stamp. Each item yields exactly one result, which shows on
// out_item while empty is low and is taken with pop.
// Throughput is one item per cycle while the consumer keeps up: the front
// end holds a one-stage register with the 16 x 16 gain multipliers, a
// two-entry queue separates it from the back end, and the back end has a
// mix-and-clamp stage followed by the slew limiter that writes a two-entry
// output buffer. The slew limiter reads and updates the last outputs in the
// same cycle, so consecutive items follow each other with no gap.
// When the consumer stalls, the output buffer fills, then the back end and
// the queue, and finally full rises; no item is dropped.
// Reset clears all queues, sets the last outputs and last time stamp to zero
// and loads the configuration registers with their defaults. Configuration
// is written through cfg_we, cfg_addr and cfg_wdata; indexes beyond the
// register list are ignored. The user must write it only while no item is
// in flight; the block itself does not enforce this.
// ============================================================================
module elevon_mixer_rate_limited (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  emrl_pkg::in_item_t                  in_item,
    output logic                                empty,
    input  logic                                pop,
    output emrl_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [emrl_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [emrl_pkg::CfgDataW-1:0]       cfg_wdata
);

    emrl_pkg::cfg_t         cfg_reg;
    emrl_pkg::cfg_t         cfg_next;
    emrl_pkg::mid_item_t    front_item;
    emrl_pkg::mid_item_t    q_item;
    logic                   front_valid;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic                   b1_valid;

    // Configuration register file. Narrow registers take the low bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                emrl_pkg::REG_ELEVATOR_GAIN:    cfg_next.elevator_gain    = cfg_wdata;
                emrl_pkg::REG_AILERON_GAIN:     cfg_next.aileron_gain     = cfg_wdata;
                emrl_pkg::REG_RUDDER_GAIN:      cfg_next.rudder_gain      = cfg_wdata;
                emrl_pkg::REG_MODE_BITS:        cfg_next.mode_bits        = cfg_wdata[3:0];
                emrl_pkg::REG_ELEVON_LIMIT:     cfg_next.elevon_limit     = cfg_wdata[14:0];
                emrl_pkg::REG_RUDDER_LIMIT:     cfg_next.rudder_limit     = cfg_wdata[14:0];
                emrl_pkg::REG_THROTTLE_FLOOR:   cfg_next.throttle_floor   = cfg_wdata;
                emrl_pkg::REG_THROTTLE_CEILING: cfg_next.throttle_ceiling = cfg_wdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.elevator_gain    <= emrl_pkg::GAIN_ONE;
            cfg_reg.aileron_gain     <= emrl_pkg::GAIN_ONE;
            cfg_reg.rudder_gain      <= emrl_pkg::GAIN_ONE;
            cfg_reg.mode_bits        <= 4'd0;
            cfg_reg.elevon_limit     <= emrl_pkg::LIMIT_ONE;
            cfg_reg.rudder_limit     <= emrl_pkg::LIMIT_ONE;
            cfg_reg.throttle_floor   <= emrl_pkg::THR_FLOOR_RST;
            cfg_reg.throttle_ceiling <= emrl_pkg::THR_CEIL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end takes items and forms products and the elapsed time.
    emrl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .valid   (front_valid),
        .item    (front_item),
        .q_full  (q_full)
    );

    // The queue lets the front end and back end stall independently.
    emrl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    // The back end mixes, clamps, slew-limits and buffers the results.
    emrl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (q_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .b1_valid (b1_valid),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

`ifndef NO_ASSERTIONS
    // Input backpressure only ever comes from a held front-end item.
    a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> front_valid)
        else $error("full raised with no item in the front register");

    // An accepted item always lands in the front register.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> front_valid)
        else $error("accepted item missing from the front register");

    // Taking an item from the queue always fills the mixing stage.
    a_pop_loads_b1: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> b1_valid)
        else $error("queue pop did not load the mixing stage");
`endif

endmodule

// ===== sv/emrl_front.sv =====
// ============================================================================
// Elevon mixer front end
// Accepts items, measures elapsed time, forms the gain products and clamps
// the throttle.
// ============================================================================
module emrl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  emrl_pkg::cfg_t       cfg,
    input  logic                 push,
    output logic                 full,
    input  emrl_pkg::in_item_t   in_item,
    output logic                 valid,
    output emrl_pkg::mid_item_t  item,
    input  logic                 q_full
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [31:0]           last_time_reg;
    emrl_pkg::mid_item_t   item_reg;
    emrl_pkg::mid_item_t   item_next;
    logic                  accept;
    logic [31:0]           elapsed;
    logic signed [15:0]    thr_hi;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign valid  = valid_reg;
    assign item   = item_reg;

    assign elapsed = in_item.time_ms - last_time_reg;

    always_comb
    begin
        thr_hi = (in_item.throttle_command > cfg.throttle_ceiling) ?
                 cfg.throttle_ceiling : in_item.throttle_command;
        item_next.elev_prod  = in_item.pitch_cmd * cfg.elevator_gain;
        item_next.ail_prod   = in_item.roll_cmd * cfg.aileron_gain;
        item_next.rud_prod   = in_item.yaw_cmd * cfg.rudder_gain;
        item_next.throttle   = (thr_hi < cfg.throttle_floor) ? cfg.throttle_floor : thr_hi;
        item_next.hold       = (elapsed == 32'd0);
        item_next.step_cap   = (elapsed > emrl_pkg::STEP_CAP_MS);
        item_next.elapsed_lo = elapsed[emrl_pkg::ElapsedW-1:0];
        valid_next = accept || (valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_time_reg <= 32'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                last_time_reg <= in_item.time_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/emrl_queue.sv =====
// ============================================================================
// Elevon mixer decoupling queue
// Two-entry queue between the front end and the back end.
// ============================================================================
module emrl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  emrl_pkg::mid_item_t  push_item,
    output logic                 full,
    input  logic                 pop,
    output emrl_pkg::mid_item_t  pop_item,
    output logic                 empty
);

    emrl_pkg::mid_item_t                 mem [emrl_pkg::QueueDepth];
    logic [emrl_pkg::QueuePtrW-1:0]      wr_ptr_reg;
    logic [emrl_pkg::QueuePtrW-1:0]      rd_ptr_reg;
    logic [emrl_pkg::QueuePtrW:0]        count_reg;
    logic [emrl_pkg::QueuePtrW:0]        count_next;
    logic                                do_push;
    logic                                do_pop;

    assign full     = (count_reg == (emrl_pkg::QueuePtrW + 1)'(emrl_pkg::QueueDepth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/emrl_back.sv =====
// ============================================================================
// Elevon mixer back end
// Scales, mixes and clamps the surfaces, applies the slew limit against the
// last outputs and buffers results for the consumer.
// ============================================================================
module emrl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  emrl_pkg::cfg_t       cfg,
    input  emrl_pkg::mid_item_t  q_item,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 b1_valid,
    output logic                 empty,
    input  logic                 pop,
    output emrl_pkg::out_item_t  out_item
);

    typedef struct packed {
        logic signed [15:0]            left_t;
        logic signed [15:0]            right_t;
        logic signed [15:0]            rudder_t;
        logic signed [15:0]            throttle;
        logic [emrl_pkg::StepW-1:0]    step;
        logic                          hold;
    } b1_t;

    function automatic logic signed [15:0] clamp_lim(input logic signed [20:0] v,
                                                     input logic [14:0] lim);
        logic signed [20:0] hi;
        logic signed [20:0] res;
        hi  = signed'({6'd0, lim});
        res = v;
        if (v > hi)
        begin
            res = hi;
        end
        if (v < -hi)
        begin
            res = -hi;
        end
        return res[15:0];
    endfunction

    function automatic logic signed [15:0] slew(input logic signed [15:0] tgt,
                                                input logic signed [15:0] prev,
                                                input logic [emrl_pkg::StepW-1:0] step);
        logic signed [17:0] chg;
        logic signed [17:0] stp;
        logic signed [18:0] res;
        chg = 18'(tgt) - 18'(prev);
        stp = signed'({1'b0, step});
        if (chg > stp)
        begin
            res = 19'(prev) + 19'(stp);
        end
        else if (chg < -stp)
        begin
            res = 19'(prev) - 19'(stp);
        end
        else
        begin
            res = 19'(tgt);
        end
        return res[15:0];
    endfunction

    b1_t                    b1_reg;
    b1_t                    b1_next;
    logic                   b1_valid_reg;
    logic                   b1_valid_next;
    logic signed [18:0]     elev_s;
    logic signed [18:0]     ail_s;
    logic signed [18:0]     rud_s;
    logic signed [20:0]     e21;
    logic signed [20:0]     a21;
    logic signed [20:0]     r21;
    logic signed [20:0]     left_mix;
    logic signed [20:0]     right_mix;
    logic [36:0]            step_prod;

    logic signed [15:0]     last_left_reg;
    logic signed [15:0]     last_right_reg;
    logic signed [15:0]     last_rudder_reg;
    emrl_pkg::out_item_t    result;

    emrl_pkg::out_item_t                 obuf [emrl_pkg::QueueDepth];
    logic [emrl_pkg::QueuePtrW-1:0]      owr_ptr_reg;
    logic [emrl_pkg::QueuePtrW-1:0]      ord_ptr_reg;
    logic [emrl_pkg::QueuePtrW:0]        ocount_reg;
    logic [emrl_pkg::QueuePtrW:0]        ocount_next;
    logic                                out_full;
    logic                                out_push;
    logic                                out_pop;

    // Stage one: scale, mix, reverse, clamp and size the step.
    always_comb
    begin
        elev_s = q_item.elev_prod[31:13];
        ail_s  = q_item.ail_prod[31:13];
        rud_s  = q_item.rud_prod[31:13];
        e21    = 21'(elev_s);
        a21    = 21'(ail_s);
        r21    = 21'(rud_s);
        if (cfg.mode_bits[emrl_pkg::MODE_ELEVON])
        begin
            left_mix  = e21 + a21;
            right_mix = e21 - a21;
            if (cfg.mode_bits[emrl_pkg::MODE_REV_LEFT])
            begin
                left_mix = -left_mix;
            end
            if (cfg.mode_bits[emrl_pkg::MODE_REV_RIGHT])
            begin
                right_mix = -right_mix;
            end
        end
        else
        begin
            left_mix  = e21;
            right_mix = a21;
        end
        if (cfg.mode_bits[emrl_pkg::MODE_REV_RUDDER])
        begin
            r21 = -r21;
        end
        step_prod        = 37'(q_item.elapsed_lo) * 37'(emrl_pkg::STEP_MUL);
        b1_next.left_t   = clamp_lim(left_mix, cfg.elevon_limit);
        b1_next.right_t  = clamp_lim(right_mix, cfg.elevon_limit);
        b1_next.rudder_t = clamp_lim(r21, cfg.rudder_limit);
        b1_next.throttle = q_item.throttle;
        b1_next.hold     = q_item.hold;
        b1_next.step     = q_item.step_cap ? emrl_pkg::STEP_CAP :
                           step_prod[emrl_pkg::StepShift +: emrl_pkg::StepW];
    end

    // Stage two: unless held, slew limit against the last outputs, into the buffer.
    always_comb
    begin
        if (b1_reg.hold)
        begin
            result.left_surface  = b1_reg.left_t;
            result.right_surface = b1_reg.right_t;
            result.rudder_out    = b1_reg.rudder_t;
        end
        else
        begin
            result.left_surface  = slew(b1_reg.left_t, last_left_reg, b1_reg.step);
            result.right_surface = slew(b1_reg.right_t, last_right_reg, b1_reg.step);
            result.rudder_out    = slew(b1_reg.rudder_t, last_rudder_reg, b1_reg.step);
        end
        result.throttle_out = b1_reg.throttle;
    end

    assign out_full  = (ocount_reg == (emrl_pkg::QueuePtrW + 1)'(emrl_pkg::QueueDepth));
    assign empty     = (ocount_reg == '0);
    assign out_push  = b1_valid_reg && !out_full;
    assign out_pop   = pop && !empty;
    assign q_pop     = !q_empty && (!b1_valid_reg || out_push);
    assign b1_valid  = b1_valid_reg;
    assign out_item  = obuf[ord_ptr_reg];

    always_comb
    begin
        b1_valid_next = q_pop || (b1_valid_reg && !out_push);
        ocount_next   = ocount_reg;
        if (out_push && !out_pop)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg    <= 1'b0;
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            last_rudder_reg <= '0;
            owr_ptr_reg     <= '0;
            ord_ptr_reg     <= '0;
            ocount_reg      <= '0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
            ocount_reg   <= ocount_next;
            if (out_push && !b1_reg.hold)
            begin
                last_left_reg   <= result.left_surface;
                last_right_reg  <= result.right_surface;
                last_rudder_reg <= result.rudder_out;
            end
            if (out_push)
            begin
                owr_ptr_reg <= owr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_reg <= b1_next;
        end
        if (out_push)
        begin
            obuf[owr_ptr_reg] <= result;
        end
    end

endmodule
